// File: design/zpconv_pkg.sv
// Shared types and constants of the zero-padded 2D convolution block.
// Used by the channel interfaces and by the top level; depends on nothing.
package zpconv_pkg;

	localparam int CH_W       = 8;
	localparam int COORD_W    = 10;
	localparam int TAP_W      = 4;
	localparam int WEIGHT_W   = 16;
	localparam int FRAC_BITS  = 12;
	localparam int PROD_W     = WEIGHT_W + CH_W + 1;
	localparam int CFG_DIM_W  = 9;
	localparam int CFG_SPAN_W = 4;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam int PIXEL_W    = 3 * CH_W;

	localparam logic [CFG_DIM_W-1:0]  RST_DIM  = 9'd256;
	localparam logic [CFG_SPAN_W-1:0] RST_SPAN = 4'd3;

	typedef enum logic [1:0] {
		OP_PIXEL  = 2'd0,
		OP_FILTER = 2'd1,
		OP_WEIGHT = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SPAN_X = 2'd2,
		REG_SPAN_Y = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

// File: design/zpconv_ifs.sv
// Valid/ready channel interfaces for requests and filtered results.
// Depends on zpconv_pkg for the field widths.
interface zpconv_req_if import zpconv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 opcode;
	logic [CH_W-1:0]            pixel_x;
	logic [CH_W-1:0]            pixel_y;
	logic [CH_W-1:0]            pixel_red;
	logic [CH_W-1:0]            pixel_green;
	logic [CH_W-1:0]            pixel_blue;
	logic [TAP_W-1:0]           tap_x;
	logic [TAP_W-1:0]           tap_y;
	logic signed [WEIGHT_W-1:0] tap_weight;

	modport source (output valid, opcode, pixel_x, pixel_y, pixel_red, pixel_green,
		pixel_blue, tap_x, tap_y, tap_weight, input ready);
	modport sink (input valid, opcode, pixel_x, pixel_y, pixel_red, pixel_green,
		pixel_blue, tap_x, tap_y, tap_weight, output ready);
endinterface

interface zpconv_rsp_if import zpconv_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] filtered_red;
	logic [CH_W-1:0] filtered_green;
	logic [CH_W-1:0] filtered_blue;

	modport source (output valid, filtered_red, filtered_green, filtered_blue, input ready);
	modport sink (input valid, filtered_red, filtered_green, filtered_blue, output ready);
endinterface

// File: design/zero_padded_2d_convolution.sv
// Top level of the zero-padded 2D convolution block: image store, kernel store,
// tap sequencer and a shared three-channel multiply-accumulate unit.
// Depends on zpconv_pkg and the interfaces in zpconv_ifs.sv.
//
//  channel | role    | transfer moves
//  --------+---------+------------------------------------------------------
//  req     | sink    | opcode, pixel coordinates and color, kernel tap/weight
//  rsp     | source  | filtered_red, filtered_green, filtered_blue
//  apb     | slave   | image_width, image_height, kernel_span_x, kernel_span_y
//
// Pixel and weight writes go to the stores when the request is taken. A filter
// request reads one tap per cycle from the image and kernel memories and feeds
// it to the multiply-accumulate unit, which drains through its s1 and s2
// registers before the result moves to the output register. A zero span skips
// the taps.
// Reset loads the default geometry and clears the kernel weights; the image
// store is not cleared. A stalled result holds in the output register and other
// requests are still taken, but a later filter result waits in the sequencer
// with the input held off until the output register frees up.
module zero_padded_2d_convolution import zpconv_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_KERNEL = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	zpconv_req_if.sink          req,
	zpconv_rsp_if.source        rsp
);

	localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW        = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KDEPTH    = MAX_KERNEL * MAX_KERNEL;
	localparam int KAW       = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
	localparam int ACC_W     = PROD_W + $clog2(KDEPTH);

	localparam logic [AW-1:0]  WIDTH_C  = AW'(MAX_WIDTH);
	localparam logic [KAW-1:0] KERNEL_C = KAW'(MAX_KERNEL);

	// Configuration registers.
	logic [CFG_DIM_W-1:0]  width_q, height_q;
	logic [CFG_SPAN_W-1:0] span_x_q, span_y_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_DIM;
			height_q <= RST_DIM;
			span_x_q <= RST_SPAN;
			span_y_q <= RST_SPAN;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
				REG_SPAN_X: span_x_q <= pwdata[CFG_SPAN_W-1:0];
				REG_SPAN_Y: span_y_q <= pwdata[CFG_SPAN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_SPAN_X: prdata = PDATA_W'(span_x_q);
			REG_SPAN_Y: prdata = PDATA_W'(span_y_q);
		endcase
	end

	// Geometry limited to the store sizes.
	logic [CFG_DIM_W-1:0]  eff_w, eff_h;
	logic [CFG_SPAN_W-1:0] eff_sx, eff_sy;

	assign eff_w  = (32'(width_q) > MAX_WIDTH) ? CFG_DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h  = (32'(height_q) > MAX_HEIGHT) ? CFG_DIM_W'(MAX_HEIGHT) : height_q;
	assign eff_sx = (32'(span_x_q) > MAX_KERNEL) ? CFG_SPAN_W'(MAX_KERNEL) : span_x_q;
	assign eff_sy = (32'(span_y_q) > MAX_KERNEL) ? CFG_SPAN_W'(MAX_KERNEL) : span_y_q;

	// Request decode.
	opcode_t op;
	logic    acc_req;
	logic    pix_wr, ker_wr, flt_start, zero_span;

	assign op        = opcode_t'(req.opcode);
	assign acc_req   = req.valid && req.ready;
	assign pix_wr    = acc_req && (op == OP_PIXEL) && (32'(req.pixel_x) < MAX_WIDTH)
		&& (32'(req.pixel_y) < MAX_HEIGHT);
	assign ker_wr    = acc_req && (op == OP_WEIGHT) && (32'(req.tap_x) < MAX_KERNEL)
		&& (32'(req.tap_y) < MAX_KERNEL);
	assign flt_start = acc_req && (op == OP_FILTER);
	assign zero_span = (eff_sx == '0) || (eff_sy == '0);

	// Sequencer state and tap counters.
	state_t                   state_q, state_d;
	logic [CFG_SPAN_W-1:0]    dx_q, dy_q;
	logic signed [COORD_W-1:0] tx_q, ty_q, tx0_q;
	logic signed [COORD_W-1:0] tx0_d, ty0_d;
	logic                     last_tap, tap_in, issue;
	logic                     load_out;
	logic                     last_s1, last_s2, vld_s1, vld_s2;

	assign tx0_d = $signed({2'b00, req.pixel_x})
		- $signed(COORD_W'((eff_sx - 4'd1) >> 1));
	assign ty0_d = $signed({2'b00, req.pixel_y})
		- $signed(COORD_W'((eff_sy - 4'd1) >> 1));

	assign last_tap = (dx_q == eff_sx - 4'd1) && (dy_q == eff_sy - 4'd1);
	assign tap_in   = !tx_q[COORD_W-1] && !ty_q[COORD_W-1]
		&& (tx_q[CFG_DIM_W-1:0] < eff_w) && (ty_q[CFG_DIM_W-1:0] < eff_h);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (flt_start) begin
					state_d = zero_span ? ST_FINISH : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_s2) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_RUN:    issue     = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: load_out  = !rsp.valid || rsp.ready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (flt_start) begin
			dx_q  <= '0;
			dy_q  <= '0;
			tx_q  <= tx0_d;
			ty_q  <= ty0_d;
			tx0_q <= tx0_d;
		end else if (issue) begin
			if (dx_q == eff_sx - 4'd1) begin
				dx_q <= '0;
				dy_q <= dy_q + 4'd1;
				tx_q <= tx0_q;
				ty_q <= ty_q + COORD_W'(1);
			end else begin
				dx_q <= dx_q + 4'd1;
				tx_q <= tx_q + COORD_W'(1);
			end
		end
	end

	// Image store: one write port, one registered read port.
	logic [PIXEL_W-1:0] img_mem [IMG_DEPTH];
	logic [PIXEL_W-1:0] img_s1;
	logic [AW-1:0]      img_waddr, img_raddr;

	assign img_waddr = AW'(req.pixel_y) * WIDTH_C + AW'(req.pixel_x);
	assign img_raddr = AW'(ty_q[CH_W-1:0]) * WIDTH_C + AW'(tx_q[CH_W-1:0]);

	always_ff @(posedge clk) begin
		if (pix_wr) begin
			img_mem[img_waddr] <= {req.pixel_red, req.pixel_green, req.pixel_blue};
		end
		if (issue) begin
			img_s1 <= img_mem[img_raddr];
		end
	end

	// Kernel store with per-entry valid bits; an unwritten weight reads as zero.
	logic [WEIGHT_W-1:0] ker_mem [KDEPTH];
	logic [KDEPTH-1:0]   kvalid_q;
	logic [WEIGHT_W-1:0] ker_s1;
	logic                kval_s1;
	logic [KAW-1:0]      ker_waddr, ker_raddr;

	assign ker_waddr = KAW'(req.tap_y) * KERNEL_C + KAW'(req.tap_x);
	assign ker_raddr = KAW'(dy_q) * KERNEL_C + KAW'(dx_q);

	always_ff @(posedge clk) begin
		if (ker_wr) begin
			ker_mem[ker_waddr] <= req.tap_weight;
		end
		if (issue) begin
			ker_s1 <= ker_mem[ker_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kvalid_q <= '0;
			kval_s1  <= 1'b0;
		end else begin
			if (ker_wr) begin
				kvalid_q[ker_waddr] <= 1'b1;
			end
			if (issue) begin
				kval_s1 <= kvalid_q[ker_raddr];
			end
		end
	end

	// Pipeline control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue && tap_in;
			last_s1 <= issue && last_tap;
			vld_s2  <= vld_s1 && kval_s1;
			last_s2 <= last_s1;
		end
	end

	// Shared multiply-accumulate unit, one tap of all three channels per cycle.
	logic signed [WEIGHT_W-1:0] w_s1;
	logic signed [PROD_W-1:0]   prod_r_s2, prod_g_s2, prod_b_s2;
	logic signed [ACC_W-1:0]    acc_r_q, acc_g_q, acc_b_q;

	assign w_s1 = $signed(ker_s1);

	always_ff @(posedge clk) begin
		prod_r_s2 <= w_s1 * $signed({1'b0, img_s1[3*CH_W-1:2*CH_W]});
		prod_g_s2 <= w_s1 * $signed({1'b0, img_s1[2*CH_W-1:CH_W]});
		prod_b_s2 <= w_s1 * $signed({1'b0, img_s1[CH_W-1:0]});
	end

	always_ff @(posedge clk) begin
		if (flt_start) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (vld_s2) begin
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
			acc_g_q <= acc_g_q + ACC_W'(prod_g_s2);
			acc_b_q <= acc_b_q + ACC_W'(prod_b_s2);
		end
	end

	function automatic logic [CH_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] acc);
		logic [CH_W-1:0] res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (|acc[ACC_W-2:FRAC_BITS+CH_W]) begin
			res = '1;
		end else begin
			res = acc[FRAC_BITS+CH_W-1:FRAC_BITS];
		end
		return res;
	endfunction

	// Output register.
	logic            rsp_valid_q;
	logic [CH_W-1:0] red_q, green_q, blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			red_q   <= clamp_ch(acc_r_q);
			green_q <= clamp_ch(acc_g_q);
			blue_q  <= clamp_ch(acc_b_q);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.filtered_red   = red_q;
	assign rsp.filtered_green = green_q;
	assign rsp.filtered_blue  = blue_q;

endmodule
